/* hdl/tcld_pkg.sv */
// shared types, constants and helper functions of the tuning command line decoder
package tcld_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

  localparam int MAX_TOKENS = 4;
  localparam int TOK_W = $clog2(MAX_TOKENS + 2);
  localparam logic [TOK_W-1:0] TOK_NONE  = TOK_W'(0);
  localparam logic [TOK_W-1:0] TOK_CMD   = TOK_W'(1);
  localparam logic [TOK_W-1:0] TOK_NAME  = TOK_W'(2);
  localparam logic [TOK_W-1:0] TOK_VALUE = TOK_W'(3);
  localparam logic [TOK_W-1:0] TOK_OVER  = TOK_W'(MAX_TOKENS + 1);

  localparam int ACC_W = 17;
  localparam logic [ACC_W-1:0] ACC_SAT = 17'd65536;
  localparam int PROD_W = 27;
  localparam logic [PROD_W-1:0] VALUE_LIMIT = 27'd65535;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_DOLLAR,
    ST_VEE,
    ST_AXIS,
    ST_TEE,
    ST_LINE
  } state_e;

  typedef enum logic [2:0] {
    CMD_GET_PARAM,
    CMD_DEFAULT,
    CMD_SAVE,
    CMD_SET,
    CMD_NONE
  } cmd_kind_e;

  typedef enum logic [2:0] {
    STS_OK,
    STS_BAD_CMD,
    STS_BAD_PARAM,
    STS_BAD_VALUE,
    STS_NO_SAVE,
    STS_TOO_LONG
  } status_e;

  typedef enum logic [2:0] {
    PRM_DB,
    PRM_KP,
    PRM_MAXSPD,
    PRM_ALPHA,
    PRM_TIMEOUT
  } param_e;

  // keyword table, left aligned and space padded to eight characters
  localparam int NUM_KW     = 10;
  localparam int KW_GET     = 0;
  localparam int KW_DEFAULT = 1;
  localparam int KW_SAVE    = 2;
  localparam int KW_SET     = 3;
  localparam int KW_PARAM   = 4;
  localparam int KW_DB      = 5;
  localparam int KW_KP      = 6;
  localparam int KW_MAXSPD  = 7;
  localparam int KW_ALPHA   = 8;
  localparam int KW_TIMEOUT = 9;
  localparam int NUM_CMD_KW = 4;

  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    "GET     ", "DEFAULT ", "SAVE    ", "SET     ", "PARAM   ",
    "DB      ", "KP      ", "MAXSPD  ", "ALPHA   ", "TIMEOUT "
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd7, 4'd4, 4'd3, 4'd5, 4'd2, 4'd2, 4'd6, 4'd5, 4'd7
  };

  typedef struct packed {
    logic        target_axis;
    cmd_kind_e   command_kind;
    status_e     status_code;
    param_e      param_id;
    logic [15:0] scaled_value;
    logic [1:0]  frac_digits;
  } cmd_t;

  function automatic logic [7:0] upcase(input logic [7:0] ch);
    if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
      return ch - 8'h20;
    end
    return ch;
  endfunction

  function automatic logic kw_char_hit(input int k, input logic [3:0] pos,
                                       input logic [7:0] ch);
    if (pos >= KW_LEN[k]) begin
      return 1'b0;
    end
    return KW_TEXT[k][63 - 8 * int'(pos[2:0]) -: 8] == ch;
  endfunction

  function automatic logic [9:0] pow_ten(input logic [1:0] e);
    logic [9:0] p;
    case (e)
      2'd0:    p = 10'd1;
      2'd1:    p = 10'd10;
      2'd2:    p = 10'd100;
      default: p = 10'd1000;
    endcase
    return p;
  endfunction

endpackage

/* hdl/tcld_rx_if.sv */
// byte channel into the decoder
interface tcld_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

/* hdl/tcld_cmd_if.sv */
// decoded command channel out of the decoder
interface tcld_cmd_if;
  logic        valid;
  logic        ready;
  logic        target_axis;
  logic [2:0]  command_kind;
  logic [2:0]  status_code;
  logic [2:0]  param_id;
  logic [15:0] scaled_value;
  logic [1:0]  frac_digits;

  modport source(output valid, output target_axis, output command_kind, output status_code,
                 output param_id, output scaled_value, output frac_digits, input ready);
  modport sink(input valid, input target_axis, input command_kind, input status_code,
               input param_id, input scaled_value, input frac_digits, output ready);
endinterface

/* hdl/tuning_command_line_decoder_core.sv */
// tuning command line decoder: prefix hunt, incremental tokenizer and command decode
// byte path: a byte is registered on transfer and processed from the byte register
//   once the output register is free; the command it causes is registered there
// throughput: one byte per cycle; the byte register and the output register decouple
//   the two channels, so only a result still held in the output register stalls input
// reset: rst_ni clears both channel valids, the prefix hunt and the line state
module tuning_command_line_decoder_core import tcld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcld_rx_if.sink     rx_i,
  tcld_cmd_if.source  cmd_o
);

  // byte register and output register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  cmd_t       out_q, out_d;
  logic       out_free, go;

  // line state
  state_e                 state_q, state_d;
  logic                   axis_yaw_q, axis_yaw_d;
  logic                   cmd_yaw_q, cmd_yaw_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [TOK_W-1:0]       ntok_q, ntok_d;
  logic                   in_tok_q, in_tok_d;
  logic [3:0]             pos_q, pos_d;
  logic [NUM_KW-1:0]      kw_q, kw_d;
  logic [NUM_CMD_KW-1:0]  tok0_q, tok0_d;
  logic [NUM_KW-NUM_CMD_KW-1:0] tok1_q, tok1_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [1:0]             pc_q, pc_d;
  logic                   pt_q, pt_d;
  logic                   dig_q, dig_d;
  logic                   bad_q, bad_d;

  logic [7:0]  ch_u;
  logic        is_print, too_long, char_go, emit;
  logic [NUM_KW-1:0] end_match;
  logic [NUM_CMD_KW-1:0] f_tok0;
  logic [NUM_KW-NUM_CMD_KW-1:0] f_tok1;
  logic        name_ok;
  param_e      name_pid;
  logic [1:0]  name_frac;
  logic [PROD_W-1:0] scaled;
  logic        value_ok;

  assign out_free   = !out_valid_q || cmd_o.ready;
  assign go         = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || out_free;

  assign ch_u     = upcase(in_byte_q);
  assign is_print = in_byte_q >= CH_SPACE && in_byte_q <= CH_TILDE;
  assign too_long = len_q >= LEN_MAX;
  assign char_go  = go && state_q == ST_LINE && is_print && !too_long;

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      end_match[k] = kw_q[k] && pos_q == KW_LEN[k];
    end
  end

  // a token still open at end of line counts as ended
  assign f_tok0 = (in_tok_q && ntok_q == TOK_CMD) ? end_match[NUM_CMD_KW-1:0] : tok0_q;
  assign f_tok1 = (in_tok_q && ntok_q == TOK_NAME) ? end_match[NUM_KW-1:NUM_CMD_KW] : tok1_q;

  // parameter name resolve, alpha exists on pitch only
  always_comb begin
    name_ok   = 1'b1;
    name_pid  = PRM_DB;
    name_frac = 2'd0;
    if (f_tok1[KW_DB - NUM_CMD_KW]) begin
      name_pid  = PRM_DB;
      name_frac = 2'd0;
    end else if (f_tok1[KW_KP - NUM_CMD_KW]) begin
      name_pid  = PRM_KP;
      name_frac = 2'd3;
    end else if (f_tok1[KW_MAXSPD - NUM_CMD_KW]) begin
      name_pid  = PRM_MAXSPD;
      name_frac = 2'd1;
    end else if (!cmd_yaw_q && f_tok1[KW_ALPHA - NUM_CMD_KW]) begin
      name_pid  = PRM_ALPHA;
      name_frac = 2'd3;
    end else if (f_tok1[KW_TIMEOUT - NUM_CMD_KW]) begin
      name_pid  = PRM_TIMEOUT;
      name_frac = 2'd0;
    end else begin
      name_ok = 1'b0;
    end
  end

  assign scaled   = PROD_W'(acc_q) * PROD_W'(pow_ten(name_frac - pc_q));
  assign value_ok = !bad_q && dig_q && scaled <= VALUE_LIMIT;

  // next state of the prefix hunt and line capture
  always_comb begin
    state_d = state_q;
    if (go) begin
      unique case (state_q)
        ST_HUNT: begin
          state_d = (in_byte_q == CH_DOLLAR) ? ST_DOLLAR : ST_HUNT;
        end
        ST_DOLLAR: begin
          if (in_byte_q == CH_V) state_d = ST_VEE;
          else state_d = (in_byte_q == CH_DOLLAR) ? ST_DOLLAR : ST_HUNT;
        end
        ST_VEE: begin
          if (in_byte_q == CH_P || in_byte_q == CH_Y) state_d = ST_AXIS;
          else state_d = (in_byte_q == CH_DOLLAR) ? ST_DOLLAR : ST_HUNT;
        end
        ST_AXIS: begin
          if (in_byte_q == CH_T) state_d = ST_TEE;
          else state_d = (in_byte_q == CH_DOLLAR) ? ST_DOLLAR : ST_HUNT;
        end
        ST_TEE: begin
          if (in_byte_q == CH_SPACE) state_d = ST_LINE;
          else state_d = (in_byte_q == CH_DOLLAR) ? ST_DOLLAR : ST_HUNT;
        end
        ST_LINE: begin
          if (in_byte_q == CH_LF) state_d = ST_HUNT;
          else if (in_byte_q == CH_CR) state_d = ST_LINE;
          else if (!is_print || too_long) state_d = ST_HUNT;
          else state_d = ST_LINE;
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  // tokenizer, keyword match and value accumulation, one char per cycle unless stalled
  always_comb begin
    logic [TOK_W-1:0] tok_idx;
    logic [3:0]       cur_pos;
    logic [NUM_KW-1:0] cur_kw;
    logic [ACC_W-1:0] cur_acc;
    logic [1:0]       cur_pc;
    logic             cur_pt, cur_dig, cur_bad;
    logic [19:0]      acc10;

    axis_yaw_d = axis_yaw_q;
    cmd_yaw_d  = cmd_yaw_q;
    len_d      = len_q;
    ntok_d     = ntok_q;
    in_tok_d   = in_tok_q;
    pos_d      = pos_q;
    kw_d       = kw_q;
    tok0_d     = tok0_q;
    tok1_d     = tok1_q;
    acc_d      = acc_q;
    pc_d       = pc_q;
    pt_d       = pt_q;
    dig_d      = dig_q;
    bad_d      = bad_q;

    tok_idx = in_tok_q ? ntok_q : ((ntok_q == TOK_OVER) ? TOK_OVER : ntok_q + TOK_W'(1));
    cur_pos = in_tok_q ? pos_q : 4'd0;
    cur_kw  = in_tok_q ? kw_q : '1;
    cur_acc = in_tok_q ? acc_q : '0;
    cur_pc  = in_tok_q ? pc_q : 2'd0;
    cur_pt  = in_tok_q && pt_q;
    cur_dig = in_tok_q && dig_q;
    cur_bad = in_tok_q && bad_q;
    acc10   = 20'(cur_acc) * 20'd10 + 20'(ch_u - CH_ZERO);

    if (go && state_q == ST_VEE) begin
      axis_yaw_d = (in_byte_q == CH_Y);
    end

    if (go && state_q == ST_TEE && in_byte_q == CH_SPACE) begin
      cmd_yaw_d = axis_yaw_q;
      len_d     = '0;
      ntok_d    = TOK_NONE;
      in_tok_d  = 1'b0;
    end

    if (char_go) begin
      len_d = len_q + LEN_W'(1);
      if (ch_u == CH_SPACE) begin
        if (in_tok_q) begin
          in_tok_d = 1'b0;
          if (ntok_q == TOK_CMD) tok0_d = end_match[NUM_CMD_KW-1:0];
          if (ntok_q == TOK_NAME) tok1_d = end_match[NUM_KW-1:NUM_CMD_KW];
        end
      end else begin
        in_tok_d = 1'b1;
        ntok_d   = tok_idx;
        pos_d    = (cur_pos == 4'd8) ? 4'd8 : cur_pos + 4'd1;
        for (int k = 0; k < NUM_KW; k++) begin
          kw_d[k] = cur_kw[k] && kw_char_hit(k, cur_pos, ch_u);
        end
        if (tok_idx == TOK_VALUE) begin
          acc_d = cur_acc;
          pc_d  = cur_pc;
          pt_d  = cur_pt;
          dig_d = cur_dig;
          bad_d = cur_bad;
          if (ch_u >= CH_ZERO && ch_u <= CH_NINE) begin
            dig_d = 1'b1;
            if (cur_pt && cur_pc >= name_frac) begin
              bad_d = 1'b1;
            end else begin
              // saturate so that a long digit string cannot wrap
              acc_d = (acc10 > 20'(VALUE_LIMIT)) ? ACC_SAT : acc10[ACC_W-1:0];
              if (cur_pt) pc_d = cur_pc + 2'd1;
            end
          end else if (ch_u == CH_DOT && !cur_pt && name_frac != 2'd0) begin
            pt_d = 1'b1;
          end else begin
            bad_d = 1'b1;
          end
        end
      end
    end
  end

  // result of the byte in process
  always_comb begin
    emit  = go && state_q == ST_LINE &&
            (in_byte_q == CH_LF || (is_print && too_long));
    out_d = '{target_axis: cmd_yaw_q, command_kind: CMD_NONE, status_code: STS_BAD_CMD,
              param_id: PRM_DB, scaled_value: 16'd0, frac_digits: 2'd0};
    if (in_byte_q != CH_LF) begin
      out_d.status_code = STS_TOO_LONG;
    end else if (ntok_q == TOK_NAME && f_tok0[KW_GET] && f_tok1[KW_PARAM - NUM_CMD_KW]) begin
      out_d.command_kind = CMD_GET_PARAM;
      out_d.status_code  = STS_OK;
    end else if (ntok_q == TOK_CMD && f_tok0[KW_DEFAULT]) begin
      out_d.command_kind = CMD_DEFAULT;
      out_d.status_code  = STS_OK;
    end else if (ntok_q == TOK_CMD && f_tok0[KW_SAVE]) begin
      out_d.command_kind = CMD_SAVE;
      out_d.status_code  = STS_NO_SAVE;
    end else if (ntok_q == TOK_VALUE && f_tok0[KW_SET]) begin
      out_d.command_kind = CMD_SET;
      if (!name_ok) begin
        out_d.status_code = STS_BAD_PARAM;
      end else begin
        out_d.param_id    = name_pid;
        out_d.frac_digits = name_frac;
        if (value_ok) begin
          out_d.status_code  = STS_OK;
          out_d.scaled_value = scaled[15:0];
        end else begin
          out_d.status_code = STS_BAD_VALUE;
        end
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_i.valid && rx_i.ready) in_valid_d = 1'b1;
    else if (go) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (emit) out_valid_d = 1'b1;
    else if (cmd_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_HUNT;
      len_q       <= '0;
      ntok_q      <= TOK_NONE;
      in_tok_q    <= 1'b0;
      axis_yaw_q  <= 1'b0;
      cmd_yaw_q   <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      len_q       <= len_d;
      ntok_q      <= ntok_d;
      in_tok_q    <= in_tok_d;
      axis_yaw_q  <= axis_yaw_d;
      cmd_yaw_q   <= cmd_yaw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) in_byte_q <= rx_i.rx_byte;
    if (emit) out_q <= out_d;
    pos_q  <= pos_d;
    kw_q   <= kw_d;
    tok0_q <= tok0_d;
    tok1_q <= tok1_d;
    acc_q  <= acc_d;
    pc_q   <= pc_d;
    pt_q   <= pt_d;
    dig_q  <= dig_d;
    bad_q  <= bad_d;
  end

  assign cmd_o.valid        = out_valid_q;
  assign cmd_o.target_axis  = out_q.target_axis;
  assign cmd_o.command_kind = out_q.command_kind;
  assign cmd_o.status_code  = out_q.status_code;
  assign cmd_o.param_id     = out_q.param_id;
  assign cmd_o.scaled_value = out_q.scaled_value;
  assign cmd_o.frac_digits  = out_q.frac_digits;

  a_tok_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ntok_q <= TOK_OVER) else $error("token count out of range");

  a_open_token_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINE && in_tok_q) |-> ntok_q != TOK_NONE)
    else $error("open token without a token count");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_MAX) else $error("line length past capacity");

  a_none_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.command_kind == CMD_NONE) |->
    (out_q.status_code == STS_BAD_CMD || out_q.status_code == STS_TOO_LONG))
    else $error("command none with unexpected status");

  a_value_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !(out_q.command_kind == CMD_SET && out_q.status_code == STS_OK)) |->
    out_q.scaled_value == 16'd0) else $error("value on a command that carries none");

  a_emit_from_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> state_q == ST_LINE && state_d == ST_HUNT)
    else $error("result without leaving the line");

endmodule

/* dv/tb_top.sv */
// self-checking testbench of the tuning command line decoder: byte stream in, decoded commands out
module tb_top import tcld_pkg::*; ();

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_BYTES = 16;

  typedef enum logic [2:0] {
    HUNT_IDLE,
    GOT_DOLLAR,
    GOT_V,
    GOT_AXIS,
    GOT_T
  } hunt_e;

  logic clk;
  logic rst_n;

  tcld_rx_if  byte_ch ();
  tcld_cmd_if cmd_ch ();

  tuning_command_line_decoder_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (byte_ch),
    .cmd_o  (cmd_ch)
  );

  // decoder state as the stream should leave it
  hunt_e       hunt_stage = HUNT_IDLE;
  logic        hunt_yaw = 1'b0;
  logic        in_line = 1'b0;
  logic        line_yaw = 1'b0;
  int          line_len = 0;
  logic [7:0]  line_buf [LINE_CAPACITY-1];

  cmd_t expected_cmds [$];
  int   errors = 0;
  int   bytes_sent = 0;
  int   cmds_predicted = 0;
  int   rx_idle_pct = 0;
  int   cmd_stall_pct = 0;
  int   quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic cmd_t make_cmd(input cmd_kind_e kind, input status_e status,
                                    input param_e pid, input logic [15:0] value,
                                    input logic [1:0] frac);
    cmd_t c;
    c.target_axis  = line_yaw;
    c.command_kind = kind;
    c.status_code  = status;
    c.param_id     = pid;
    c.scaled_value = value;
    c.frac_digits  = frac;
    return c;
  endfunction

  function automatic void expect_cmd(input cmd_t c);
    expected_cmds.push_back(c);
    cmds_predicted++;
  endfunction

  function automatic void close_line();
    in_line    = 1'b0;
    line_len   = 0;
    line_yaw   = 1'b0;
    hunt_yaw   = 1'b0;
    hunt_stage = HUNT_IDLE;
  endfunction

  function automatic hunt_e restart_on(input logic [7:0] b);
    return (b == CH_DOLLAR) ? GOT_DOLLAR : HUNT_IDLE;
  endfunction

  function automatic bit word_at(input int start, input int len, input string w);
    if (len != w.len()) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (line_buf[start + k] != w[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit scale_value(input int start, input int len, input int frac,
                                     output logic [15:0] value);
    longint unsigned whole, part, scaled;
    int              part_digits;
    bit              got_digit, got_point;
    logic [7:0]      ch;
    whole = 0;
    part = 0;
    part_digits = 0;
    got_digit = 1'b0;
    got_point = 1'b0;
    value = '0;
    for (int k = 0; k < len; k++) begin
      ch = line_buf[start + k];
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        got_digit = 1'b1;
        if (!got_point) begin
          whole = whole * 10 + (ch - CH_ZERO);
          // saturate so any length of digit string stays over the limit
          if (whole > 65535) whole = 65536;
        end else begin
          if (part_digits >= frac) return 1'b0;
          part = part * 10 + (ch - CH_ZERO);
          part_digits++;
        end
      end else if (ch == CH_DOT && !got_point && frac != 0) begin
        got_point = 1'b1;
      end else begin
        return 1'b0;
      end
    end
    if (!got_digit) return 1'b0;
    scaled = whole * (10 ** frac) + part * (10 ** (frac - part_digits));
    if (scaled > 65535) return 1'b0;
    value = scaled[15:0];
    return 1'b1;
  endfunction

  function automatic cmd_t decode_line();
    int          starts [MAX_TOKENS];
    int          lens [MAX_TOKENS];
    int          n, i, frac;
    param_e      pid;
    logic [15:0] value;
    for (i = 0; i < line_len; i++) begin
      if (line_buf[i] >= CH_LOW_A && line_buf[i] <= CH_LOW_Z) line_buf[i] = line_buf[i] - 8'h20;
    end
    n = 0;
    i = 0;
    while (i < line_len) begin
      while (i < line_len && line_buf[i] == CH_SPACE) i++;
      if (i >= line_len) break;
      if (n >= MAX_TOKENS) begin
        n = MAX_TOKENS + 1;
        break;
      end
      starts[n] = i;
      while (i < line_len && line_buf[i] != CH_SPACE) i++;
      lens[n] = i - starts[n];
      n++;
    end

    if (n == 2 && word_at(starts[0], lens[0], "GET") && word_at(starts[1], lens[1], "PARAM"))
      return make_cmd(CMD_GET_PARAM, STS_OK, PRM_DB, '0, '0);
    if (n == 1 && word_at(starts[0], lens[0], "DEFAULT"))
      return make_cmd(CMD_DEFAULT, STS_OK, PRM_DB, '0, '0);
    if (n == 1 && word_at(starts[0], lens[0], "SAVE"))
      return make_cmd(CMD_SAVE, STS_NO_SAVE, PRM_DB, '0, '0);
    if (n != 3 || !word_at(starts[0], lens[0], "SET"))
      return make_cmd(CMD_NONE, STS_BAD_CMD, PRM_DB, '0, '0);

    if (word_at(starts[1], lens[1], "DB")) begin
      pid = PRM_DB;
      frac = 0;
    end else if (word_at(starts[1], lens[1], "KP")) begin
      pid = PRM_KP;
      frac = 3;
    end else if (word_at(starts[1], lens[1], "MAXSPD")) begin
      pid = PRM_MAXSPD;
      frac = 1;
    end else if (!line_yaw && word_at(starts[1], lens[1], "ALPHA")) begin
      pid = PRM_ALPHA;
      frac = 3;
    end else if (word_at(starts[1], lens[1], "TIMEOUT")) begin
      pid = PRM_TIMEOUT;
      frac = 0;
    end else begin
      return make_cmd(CMD_SET, STS_BAD_PARAM, PRM_DB, '0, '0);
    end
    if (!scale_value(starts[2], lens[2], frac, value))
      return make_cmd(CMD_SET, STS_BAD_VALUE, pid, '0, 2'(frac));
    return make_cmd(CMD_SET, STS_OK, pid, value, 2'(frac));
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    if (in_line) begin
      if (b == CH_CR) return;
      if (b == CH_LF) begin
        if (line_len != 0) expect_cmd(decode_line());
        else expect_cmd(make_cmd(CMD_NONE, STS_BAD_CMD, PRM_DB, '0, '0));
        close_line();
      end else if (b < CH_SPACE || b > CH_TILDE) begin
        // control byte drops the line without a word
        close_line();
      end else if (line_len >= LINE_CAPACITY - 1) begin
        expect_cmd(make_cmd(CMD_NONE, STS_TOO_LONG, PRM_DB, '0, '0));
        close_line();
      end else begin
        line_buf[line_len] = b;
        line_len++;
      end
      return;
    end
    case (hunt_stage)
      HUNT_IDLE:  hunt_stage = restart_on(b);
      GOT_DOLLAR: hunt_stage = (b == CH_V) ? GOT_V : restart_on(b);
      GOT_V: begin
        if (b == CH_P || b == CH_Y) begin
          hunt_yaw   = (b == CH_Y);
          hunt_stage = GOT_AXIS;
        end else begin
          hunt_stage = restart_on(b);
        end
      end
      GOT_AXIS:   hunt_stage = (b == CH_T) ? GOT_T : restart_on(b);
      GOT_T: begin
        if (b == CH_SPACE) begin
          in_line    = 1'b1;
          line_len   = 0;
          line_yaw   = hunt_yaw;
          hunt_stage = HUNT_IDLE;
        end else begin
          hunt_stage = restart_on(b);
        end
      end
      default:    close_line();
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] b);
    // each idle cycle is drawn on its own so the idle share matches the percentage
    while (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid   = 1'b1;
    byte_ch.rx_byte = b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic send_line(input bit yaw, input string body);
    if (yaw) send_text("$VYT ");
    else send_text("$VPT ");
    send_text(body);
    send_byte(CH_LF);
  endtask

  task automatic wait_drained();
    byte_ch.valid = 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
  endtask

  initial begin
    cmd_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cmd_ch.ready = ($urandom_range(99) >= cmd_stall_pct);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_cmds
    cmd_t want;
    if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
      if (expected_cmds.size() == 0) begin
        $error("command with none expected: kind %0d status %0d",
               cmd_ch.command_kind, cmd_ch.status_code);
        errors++;
      end else begin
        want = expected_cmds.pop_front();
        check_field("target_axis", want.target_axis, cmd_ch.target_axis);
        check_field("command_kind", want.command_kind, cmd_ch.command_kind);
        check_field("status_code", want.status_code, cmd_ch.status_code);
        check_field("param_id", want.param_id, cmd_ch.param_id);
        check_field("scaled_value", want.scaled_value, cmd_ch.scaled_value);
        check_field("frac_digits", want.frac_digits, cmd_ch.frac_digits);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (byte_ch.valid && byte_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL tuning_command_line_decoder_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- random lines

  function automatic string rand_case(input string s);
    string r;
    r = s;
    for (int k = 0; k < r.len(); k++) begin
      if (r[k] >= "A" && r[k] <= "Z" && $urandom_range(1) == 1) r[k] = r[k] + 8'h20;
    end
    return r;
  endfunction

  function automatic string rand_digits(input int count);
    string s;
    s = "";
    repeat (count) s = {s, $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  function automatic string rand_value();
    string s;
    case ($urandom_range(7))
      0: s = $sformatf("%0d", $urandom_range(9));
      1: s = $sformatf("%0d", $urandom_range(65535));
      2: s = $sformatf("%0d", $urandom_range(65530, 70000));
      3: s = {$sformatf("%0d.", $urandom_range(70)), rand_digits($urandom_range(4))};
      4: s = {".", rand_digits($urandom_range(3))};
      5: s = rand_digits($urandom_range(6, 24));
      6: begin
        case ($urandom_range(4))
          0: s = "1.2.3";
          1: s = "-5";
          2: s = "12A";
          3: s = "0X10";
          default: s = "+1";
        endcase
      end
      default: s = $sformatf("%0d.%0d", $urandom_range(6553), $urandom_range(9));
    endcase
    return s;
  endfunction

  function automatic string rand_name();
    string s;
    case ($urandom_range(9))
      0, 5: s = "DB";
      1, 6: s = "KP";
      2, 9: s = "MAXSPD";
      3, 7: s = "ALPHA";
      4:    s = "TIMEOUT";
      default: begin
        case ($urandom_range(3))
          0: s = "DBX";
          1: s = "K";
          2: s = "ALPH";
          default: s = "TIMEOUTS";
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic string rand_body();
    string toks [$];
    string s;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      toks.push_back("GET");
      toks.push_back("PARAM");
    end else if (pick < 18) begin
      toks.push_back("DEFAULT");
    end else if (pick < 26) begin
      toks.push_back("SAVE");
    end else if (pick < 76) begin
      toks.push_back("SET");
      toks.push_back(rand_name());
      toks.push_back(rand_value());
    end else if (pick < 84) begin
      // GET or SET followed by zero to three parameter names
      toks.push_back($urandom_range(1) ? "GET" : "SET");
      repeat ($urandom_range(3)) toks.push_back(rand_name());
    end else if (pick < 92) begin
      case ($urandom_range(3))
        0: toks.push_back("GETPARAM");
        1: toks.push_back("RESET");
        2: toks.push_back("SAV");
        default: toks.push_back("DEFAULTS");
      endcase
    end else if (pick < 96) begin
      toks.push_back("SET");
      toks.push_back(rand_name());
      toks.push_back(rand_value());
      repeat ($urandom_range(1, 3)) toks.push_back(rand_value());
    end
    s = "";
    foreach (toks[k]) begin
      if (k != 0 || $urandom_range(5) == 0) repeat ($urandom_range(1, 2)) s = {s, " "};
      s = {s, rand_case(toks[k])};
    end
    if ($urandom_range(5) == 0) s = {s, " "};
    return s;
  endfunction

  task automatic send_random_line();
    string      body, prefix;
    int         pick, cut;
    logic [7:0] ctrl;
    pick = $urandom_range(99);
    body = rand_body();
    prefix = $urandom_range(1) ? "$VYT " : "$VPT ";
    if (pick < 8) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
    end else if (pick < 12) begin
      // prefix that breaks off or restarts on a dollar sign
      case ($urandom_range(4))
        0: send_text("$VP");
        1: send_text("$VYX");
        2: send_text("$VPTT");
        3: send_text("VPT ");
        default: send_text("$VY$");
      endcase
      send_text(body);
      send_byte(CH_LF);
    end else if (pick < 16) begin
      do begin
        ctrl = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(127, 255));
      end while (ctrl == CH_CR || ctrl == CH_LF);
      cut = $urandom_range(body.len());
      send_text(prefix);
      for (int k = 0; k < cut; k++) send_byte(body[k]);
      send_byte(ctrl);
      for (int k = cut; k < body.len(); k++) send_byte(body[k]);
      send_byte(CH_LF);
    end else if (pick < 18) begin
      send_text(prefix);
      repeat ($urandom_range(60, 66)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
      send_byte(CH_LF);
    end else begin
      send_text(prefix);
      for (int k = 0; k < body.len(); k++) begin
        if ($urandom_range(40) == 0) send_byte(CH_CR);
        send_byte(body[k]);
      end
      if ($urandom_range(1)) send_byte(CH_CR);
      send_byte(CH_LF);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_commands();
    send_text("$VPT GET PARAM");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_line(1'b1, "default");
    send_line(1'b0, "Save");
    send_line(1'b1, " get  param ");
    send_line(1'b0, "A B C D E");
    send_line(1'b1, "");
    wait_drained();
  endtask

  task automatic test_values();
    send_line(1'b0, "SET KP 65.535");
    send_line(1'b1, "SET ALPHA 1");
    send_line(1'b0, "set alpha .5");
    send_line(1'b0, "SET DB 1.0");
    send_line(1'b0, "SET KP 1.2345");
    // wraps to one in 32 bits, must still be over the limit
    send_line(1'b0, "SET DB 4294967297");
    send_line(1'b1, "SET MAXSPD 5.");
    wait_drained();
  endtask

  task automatic test_prefix_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$V$VYT GET PARAM");
    send_byte(CH_LF);
    send_text("$VPT$VYT DEFAULT");
    send_byte(CH_LF);
    send_text("$$VPT SAVE");
    send_byte(CH_LF);
    wait_drained();
  endtask

  task automatic test_line_faults();
    send_text("$VPT GET");
    send_byte(8'h01);
    send_text(" PARAM");
    send_byte(CH_LF);
    send_text("$VYT SAVE");
    send_byte(8'h7F);
    send_byte(CH_LF);
    send_text("$VPT DEF");
    send_byte(CH_CR);
    send_text("AULT");
    send_byte(CH_CR);
    send_byte(CH_LF);
    // a full line still decodes, one more printable byte overflows it
    send_text("$VPT ");
    repeat (LINE_CAPACITY - 1) send_byte("A");
    send_byte(CH_LF);
    send_text("$VYT ");
    repeat (LINE_CAPACITY) send_byte("b");
    send_byte(CH_LF);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int bytes_start;
    rx_idle_pct   = idle_pct;
    cmd_stall_pct = stall_pct;
    bytes_start   = bytes_sent;
    while (bytes_sent - bytes_start < PHASE_BYTES) begin
      send_random_line();
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.rx_byte = 8'h00;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_commands();
    test_values();
    test_prefix_hunt();
    test_line_faults();
    test_random_traffic(0, 0);
    test_random_traffic(58, 0);
    test_random_traffic(0, 58);
    test_random_traffic(8, 8);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("PASS tuning_command_line_decoder_core");
    end else begin
      $display("FAIL tuning_command_line_decoder_core");
    end
    $finish;
  end

endmodule
